// ----- rtl/h2b_pkg.sv -----
package h2b_pkg;

  // One input word: a single ASCII hex digit and its end-of-string mark.
  typedef struct packed {
    logic [7:0] hex_char;
    logic       last_char;
  } in_word_t;

  // One result word: a single base64 character and its end-of-string mark.
  typedef struct packed {
    logic [7:0] b64_char;
    logic       last_out;
  } out_word_t;

  // One encoding job: 24 bits of group data, number of pad characters, end mark.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  pad;
    logic        last;
  } job_t;

  // Status of the job queue as seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] CharPad   = 8'd61;   // '='
  localparam logic [7:0] CharPlus  = 8'd43;   // '+'
  localparam logic [7:0] CharSlash = 8'd47;   // '/'
  localparam logic [7:0] CharUpA   = 8'd65;   // 'A'
  localparam logic [7:0] CharUpF   = 8'd70;   // 'F'
  localparam logic [7:0] CharLoA   = 8'd97;   // 'a'
  localparam logic [7:0] CharLoF   = 8'd102;  // 'f'

  localparam logic [1:0] PadNone = 2'd0;
  localparam logic [1:0] PadOne  = 2'd1;
  localparam logic [1:0] PadTwo  = 2'd2;

  // Value of one hex digit; any other code gives the low four bits of code minus 48.
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= CharUpA && c <= CharUpF) begin
        t = c - 8'd55;
      end else if (c >= CharLoA && c <= CharLoF) begin
        t = c - 8'd87;
      end else begin
        t = {4'd0, c[3:0]};
      end
      return t[3:0];
    end
  endfunction

  // Standard base64 alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    begin
      if (v < 6'd26) begin
        c = CharUpA + {2'b00, v};
      end else if (v < 6'd52) begin
        c = 8'd71 + {2'b00, v};
      end else if (v < 6'd62) begin
        c = {2'b00, v} - 8'd4;
      end else if (v == 6'd62) begin
        c = CharPlus;
      end else begin
        c = CharSlash;
      end
      return c;
    end
  endfunction

endpackage

// ----- rtl/h2b_front.sv -----
module h2b_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_odd_length,
  input  logic              in_push,
  output logic              in_full,
  input  h2b_pkg::in_word_t in_word,
  input  h2b_pkg::q_stat_t  q_stat,
  output logic              job_push,
  output h2b_pkg::job_t     job
);
  import h2b_pkg::*;

  logic        odd_length_r;
  logic [3:0]  held_r, held_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] grp_r, grp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        first_r, first_nxt;

  logic        accept;
  logic [3:0]  v;
  logic        have_byte;
  logic [7:0]  byte_val;

  // The register is always writable; the user must write it only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;
  assign accept    = in_push && !q_stat.full;

  // Pair digits into bytes, collect bytes into groups and issue jobs.
  always_comb begin
    v         = digit_value(in_word.hex_char);
    held_nxt  = held_r;
    pend_nxt  = pend_r;
    grp_nxt   = grp_r;
    cnt_nxt   = cnt_r;
    first_nxt = 1'b0;
    have_byte = 1'b0;
    byte_val  = 8'd0;
    job_push  = 1'b0;
    job       = '0;

    if (first_r && odd_length_r) begin
      byte_val  = {4'd0, v};
      have_byte = 1'b1;
    end else if (!pend_r) begin
      held_nxt = v;
      pend_nxt = 1'b1;
    end else begin
      byte_val  = {held_r, v};
      pend_nxt  = 1'b0;
      have_byte = 1'b1;
    end

    // A final digit left without a partner forms the high half of a byte.
    if (in_word.last_char && pend_nxt) begin
      byte_val  = {held_nxt, 4'd0};
      pend_nxt  = 1'b0;
      have_byte = 1'b1;
    end

    if (have_byte) begin
      if (cnt_r == 2'd2) begin
        job_push = 1'b1;
        job.word = {grp_r, byte_val};
        job.pad  = PadNone;
        job.last = in_word.last_char;
        grp_nxt  = 16'd0;
        cnt_nxt  = 2'd0;
      end else begin
        grp_nxt = {grp_r[7:0], byte_val};
        cnt_nxt = cnt_r + 2'd1;
      end
    end

    // End of string: flush a partial group with padding and start over.
    if (in_word.last_char) begin
      if (cnt_nxt == 2'd1) begin
        job_push = 1'b1;
        job.word = {grp_nxt[7:0], 16'd0};
        job.pad  = PadTwo;
        job.last = 1'b1;
      end else if (cnt_nxt == 2'd2) begin
        job_push = 1'b1;
        job.word = {grp_nxt, 8'd0};
        job.pad  = PadOne;
        job.last = 1'b1;
      end
      held_nxt  = 4'd0;
      pend_nxt  = 1'b0;
      grp_nxt   = 16'd0;
      cnt_nxt   = 2'd0;
      first_nxt = 1'b1;
    end

    if (!accept) begin
      job_push = 1'b0;
    end
  end

  // Front state and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_length_r <= 1'b0;
      held_r       <= 4'd0;
      pend_r       <= 1'b0;
      grp_r        <= 16'd0;
      cnt_r        <= 2'd0;
      first_r      <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        odd_length_r <= cfg_odd_length;
      end
      if (accept) begin
        held_r  <= held_nxt;
        pend_r  <= pend_nxt;
        grp_r   <= grp_nxt;
        cnt_r   <= cnt_nxt;
        first_r <= first_nxt;
      end
    end
  end

endmodule

// ----- rtl/h2b_queue.sv -----
module h2b_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  h2b_pkg::job_t    push_job,
  input  logic             pop,
  output h2b_pkg::job_t    head,
  output h2b_pkg::q_stat_t stat
);
  import h2b_pkg::*;

  job_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == QCntW'(QDepth));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCntW'(1);
      end
    end
  end

endmodule

// ----- rtl/h2b_back.sv -----
module h2b_back (
  input  logic               clk,
  input  logic               rst_n,
  input  h2b_pkg::q_stat_t   q_stat,
  input  h2b_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output h2b_pkg::out_word_t out_word
);
  import h2b_pkg::*;

  logic [1:0] idx_r;
  logic       valid_r;
  out_word_t  word_r;
  logic       load;
  logic [5:0] sextet;
  out_word_t  word_nxt;

  assign out_empty = !valid_r;
  assign out_word  = word_r;
  assign load      = !q_stat.empty && (!valid_r || out_pop);
  assign q_pop     = load && (idx_r == 2'd3);

  // Pick the current character of the head job.
  always_comb begin
    case (idx_r)
      2'd0:    sextet = q_head.word[23:18];
      2'd1:    sextet = q_head.word[17:12];
      2'd2:    sextet = q_head.word[11:6];
      2'd3:    sextet = q_head.word[5:0];
      default: sextet = 6'd0;
    endcase
    if ({1'b0, idx_r} >= (3'd4 - {1'b0, q_head.pad})) begin
      word_nxt.b64_char = CharPad;
    end else begin
      word_nxt.b64_char = sextet_char(sextet);
    end
    word_nxt.last_out = q_head.last && (idx_r == 2'd3);
  end

  // Output register and character counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= idx_r + 2'd1;
        valid_r <= 1'b1;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ----- rtl/hex_to_base64_encoder.sv -----
// Hex digit to base64 character converter.
// Input channel: one ASCII hex digit per word with last_char marking the end
// of the string; a word is taken when in_push is high and in_full is low.
// A digit can be taken every cycle while the job queue has room.
// Output channel: one base64 character per word; the oldest character sits
// on out_word while out_empty is low and leaves when out_pop is high.
// Four characters come out for every three bytes, and a final partial group
// is padded with '='; the final character carries last_out.
// A group's job enters the job queue as the digit completing it is taken; the
// first character then loads into the output register and the other three follow.
// Throughput: one digit per cycle in while the queue has room, one character
// per cycle out while out_pop is high; the four-deep job queue between the
// digit front end and the character back end absorbs bursts of short strings.
// Configuration: cfg_odd_length is written on cfg_valid with cfg_ready, which is
// always high; the user must do so only while the block is idle (not enforced).
// Reset (synchronous, rst_n low) empties the queue and the output register,
// clears odd_length and starts at the first digit of a string.
// When the receiver stalls the output word holds, the queue fills and in_full
// then holds off further digits.
module hex_to_base64_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_odd_length,
  input  logic               in_push,
  output logic               in_full,
  input  h2b_pkg::in_word_t  in_word,
  output logic               out_empty,
  input  logic               out_pop,
  output h2b_pkg::out_word_t out_word
);
  import h2b_pkg::*;

  q_stat_t q_stat;
  logic    job_push;
  job_t    job;
  job_t    q_head;
  logic    q_pop;

  h2b_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_odd_length (cfg_odd_length),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_word        (in_word),
    .q_stat         (q_stat),
    .job_push       (job_push),
    .job            (job)
  );

  h2b_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  h2b_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

`ifndef SYNTH
  // The end of a string always produces a job.
  a_last_makes_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_word.last_char) |-> job_push)
    else $error("final digit produced no job");

  // Jobs are issued only for accepted digits.
  a_job_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (in_push && !in_full))
    else $error("job issued without an accepted digit");

  // The queue is never full and empty at once.
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  // A job with padding is always the end of a string.
  a_pad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (job_push && job.pad != PadNone) |-> job.last)
    else $error("padded job not marked last");
`endif

endmodule

// ----- tb/sv/hex_to_base64_encoder_tb.sv -----
module hex_to_base64_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import h2b_pkg::*;

  localparam int unsigned CyclePeriod = 20;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_odd_length = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_word_t in_word = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_word_t out_word;

  // Idle chances of the two sides, in percent.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Characters still to come out, oldest first.
  out_word_t pending_chars[$];
  out_word_t want;

  // Encoder state as the predictor tracks it.
  logic [3:0] held_nib;
  logic nib_pending;
  logic [15:0] grp_bytes;
  logic [1:0] grp_count;
  logic first_digit;
  logic odd_len;

  hex_to_base64_encoder u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_odd_length(cfg_odd_length),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_word       (in_word),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_word      (out_word)
  );

  always #(CyclePeriod / 2) clk = ~clk;

  // The run is cut off if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Value of one digit; a non-hex code keeps the low four bits of code minus 48.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    if (c >= "A" && c <= "F") begin
      t = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      t = c - "a" + 8'd10;
    end else begin
      t = c - 8'd48;
    end
    return t[3:0];
  endfunction

  // Base64 character for a six-bit value.
  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    if (v < 6'd26) begin
      return "A" + {2'b00, v};
    end else if (v < 6'd52) begin
      return "a" + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      return "0" + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      return CharPlus;
    end
    return CharSlash;
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic last);
    out_word_t w;
    w.b64_char = ch;
    w.last_out = last;
    pending_chars.push_back(w);
  endtask

  task automatic clear_string_state();
    held_nib = '0;
    nib_pending = 1'b0;
    grp_bytes = '0;
    grp_count = '0;
    first_digit = 1'b1;
  endtask

  // Works out the characters that one accepted digit word causes.
  task automatic encode_digit(input in_word_t w);
    logic [3:0] v;
    logic have_byte;
    logic [7:0] b;
    logic [23:0] g;
    v = hex_nibble(w.hex_char);
    have_byte = 1'b0;
    b = '0;
    if (first_digit && odd_len) begin
      b = {4'd0, v};
      have_byte = 1'b1;
    end else if (!nib_pending) begin
      held_nib = v;
      nib_pending = 1'b1;
    end else begin
      b = {held_nib, v};
      nib_pending = 1'b0;
      have_byte = 1'b1;
    end
    first_digit = 1'b0;

    // A final digit without a partner becomes the high half of a byte.
    if (w.last_char && nib_pending) begin
      b = {held_nib, 4'd0};
      nib_pending = 1'b0;
      have_byte = 1'b1;
    end

    if (have_byte) begin
      if (grp_count == 2'd2) begin
        g = {grp_bytes, b};
        push_char(b64_symbol(g[23:18]), 1'b0);
        push_char(b64_symbol(g[17:12]), 1'b0);
        push_char(b64_symbol(g[11:6]), 1'b0);
        push_char(b64_symbol(g[5:0]), w.last_char);
        grp_bytes = '0;
        grp_count = '0;
      end else begin
        grp_bytes = {grp_bytes[7:0], b};
        grp_count = grp_count + 2'd1;
      end
    end

    // The end of the string flushes a short group with padding.
    if (w.last_char) begin
      if (grp_count == 2'd1) begin
        push_char(b64_symbol(grp_bytes[7:2]), 1'b0);
        push_char(b64_symbol({grp_bytes[1:0], 4'd0}), 1'b0);
        push_char(CharPad, 1'b0);
        push_char(CharPad, 1'b1);
      end else if (grp_count == 2'd2) begin
        push_char(b64_symbol(grp_bytes[15:10]), 1'b0);
        push_char(b64_symbol(grp_bytes[9:4]), 1'b0);
        push_char(b64_symbol({grp_bytes[3:0], 2'b00}), 1'b0);
        push_char(CharPad, 1'b1);
      end
      clear_string_state();
    end
  endtask

  // Sends one digit word and records its characters once it is taken.
  task automatic send_word(input logic [7:0] c, input logic last);
    in_word_t w;
    w.hex_char = c;
    w.last_char = last;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_push <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_word <= w;
    do begin
      @(posedge clk);
    end while (in_full);
    encode_digit(w);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], i == s.len() - 1);
    end
  endtask

  // Stops pushing, then waits until every expected character has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_odd_length(input logic v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_odd_length <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    odd_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_digit();
    string digits;
    digits = "0123456789ABCDEFabcdef";
    if ($urandom_range(99) < 85) begin
      return digits[$urandom_range(21)];
    end
    return 8'($urandom_range(255));
  endfunction

  // Short strings covering the field extremes and every special case.
  task automatic test_directed();
    send_idle_pct = 19;
    recv_idle_pct = 62;
    write_odd_length(1'b0);
    // An unpaired final digit.
    send_string("F");
    // A real zero byte, flushed as a one-byte group.
    send_string("00");
    // Two bytes giving the plus and slash symbols, flushed with one pad.
    send_string("fBfF");
    // A full group built from non-hex codes and code extremes.
    send_word("9", 1'b0);
    send_word("Z", 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word("g", 1'b0);
    send_word("a", 1'b1);
    write_odd_length(1'b1);
    // The first digit standing alone as a byte.
    send_string("a");
    send_string("Cffffff");
  endtask

  // Holds off the sender mid-string until every character has drained.
  task automatic test_drain_pause();
    send_idle_pct = 19;
    recv_idle_pct = 62;
    write_odd_length(1'b0);
    send_string("abcdef");
    send_word("0", 1'b0);
    wait_drained();
    send_word("1", 1'b0);
    send_word("2", 1'b0);
    send_word("7", 1'b1);
  endtask

  // Random strings, mostly well formed for the given setting.
  task automatic test_random(input int unsigned n_digits, input int unsigned s_idle,
                             input int unsigned r_idle, input logic odd);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    write_odd_length(odd);
    sent = 0;
    while (sent < n_digits) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(8, 1);
      end else if (r < 92) begin
        len = $urandom_range(20, 9);
      end else begin
        len = $urandom_range(40, 21);
      end
      // Most strings get the digit count that matches the setting.
      if ($urandom_range(99) < 80 && (len[0] != odd)) begin
        len = len + 1;
      end
      for (int i = 0; i < len; i++) begin
        send_word(random_digit(), i == len - 1);
      end
      sent = sent + len;
    end
  endtask

  // The receiver pops at random.
  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each character that leaves is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: b64_char %h last_out %b", out_word.b64_char,
               out_word.last_out);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_word.b64_char !== want.b64_char) begin
          $error("b64_char: expected %h, got %h", want.b64_char, out_word.b64_char);
          fail_count++;
        end
        if (out_word.last_out !== want.last_out) begin
          $error("last_out: expected %b, got %b", want.last_out, out_word.last_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    clear_string_state();
    odd_len = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_drain_pause();
    test_random(30, 19, 62, 1'b0);
    test_random(30, 19, 62, 1'b1);
    test_random(30, 62, 19, 1'b1);
    test_random(30, 62, 19, 1'b0);
    test_random(25, 0, 0, 1'b0);
    test_random(25, 0, 0, 1'b1);

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("%0d expected words never arrived", pending_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/h2b_pkg.sv
rtl/h2b_front.sv
rtl/h2b_queue.sv
rtl/h2b_back.sv
rtl/hex_to_base64_encoder.sv
tb/sv/hex_to_base64_encoder_tb.sv
